// ===== design/look_at_view_matrix_macros.svh =====
// assertion macros for the look-at view matrix checker
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LAVM_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("look-at view matrix check failed");

// next-cycle implication
`define LAVM_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("look-at view matrix check failed");

`endif

// ===== design/lavm_pkg.sv =====
// shared types and constants for the look-at view matrix block
package lavm_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// row codes on row_number
	localparam logic [1:0] ROW_SIDE  = 2'd0;
	localparam logic [1:0] ROW_UP    = 2'd1;
	localparam logic [1:0] ROW_FWD   = 2'd2;
	localparam logic [1:0] ROW_TRANS = 2'd3;

	// one classified item between front and back
	typedef struct packed {
		logic [2:0][32:0] dlt;
		logic [2:0][31:0] eye;
		logic [2:0][31:0] up;
		logic             dlt_zero;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ABS,
		ST_SCALE,
		ST_SQ,
		ST_ROOT,
		ST_DLOAD,
		ST_DIV,
		ST_MAC,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MAC_CROSS,
		MAC_UP,
		MAC_DOT
	} mac_op_t;

endpackage

// ===== design/lavm_front.sv =====
// front end: accepts beats, forms target minus eye, queues the item
module lavm_front #(
	parameter int DEPTH = lavm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  target_x,
	input  logic signed [31:0]  target_y,
	input  logic signed [31:0]  target_z,
	input  logic signed [31:0]  eye_x,
	input  logic signed [31:0]  eye_y,
	input  logic signed [31:0]  eye_z,
	input  logic signed [31:0]  up_x,
	input  logic signed [31:0]  up_y,
	input  logic signed [31:0]  up_z,
	output lavm_pkg::item_t     q_item,
	output logic                q_valid,
	input  logic                q_pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lavm_pkg::item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	lavm_pkg::item_t  item_in;
	logic             push, pop;

	always_comb begin
		item_in.dlt[0] = 33'(target_x) - 33'(eye_x);
		item_in.dlt[1] = 33'(target_y) - 33'(eye_y);
		item_in.dlt[2] = 33'(target_z) - 33'(eye_z);
		item_in.eye[0] = eye_x;
		item_in.eye[1] = eye_y;
		item_in.eye[2] = eye_z;
		item_in.up[0]  = up_x;
		item_in.up[1]  = up_y;
		item_in.up[2]  = up_z;
		// eye on the target: no forward axis
		item_in.dlt_zero = (item_in.dlt == '0);
	end

	assign in_stall = (count_q == CNT_W'(DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign pop      = q_valid && q_pop;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/lavm_back.sv =====
// back end: normalise, cross, dot and row emission sequencer
module lavm_back #(
	parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lavm_pkg::item_t    q_item,
	input  logic               q_valid,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] elem_0,
	output logic signed [31:0] elem_1,
	output logic signed [31:0] elem_2,
	output logic signed [31:0] elem_3,
	output logic [1:0]         row_number,
	output logic               last_row,
	output logic               degenerate
);

	localparam int QW   = FRAC_BITS + 2;
	localparam int CW   = $clog2(QW);
	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] MAXV = 64'sh7FFF_FFFF;
	localparam logic signed [63:0] MINV = -64'sh8000_0000;
	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	function automatic logic [1:0] nx3(input logic [1:0] k);
		logic [1:0] r;
		case (k)
			2'd0:    r = 2'd1;
			2'd1:    r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	lavm_pkg::state_t  state_q, state_d;
	lavm_pkg::mac_op_t op_q;

	logic signed [63:0] vec_q [3];
	logic [63:0]        mag_q [3];
	logic [2:0]         neg_q;
	logic               pass_q;
	logic signed [63:0] acc_q;
	logic [1:0]         k_q, step_q;
	logic [63:0]        rn_q, rr_q, rbit_q;
	logic [31:0]        len_q;
	logic [63:0]        rem_q, den_q;
	logic [QW-1:0]      quo_q;
	logic [CW-1:0]      cnt_q;
	logic signed [31:0] f_q [3], s_q [3], u_q [3], t_q [3], eye_q [3], up_q [3];
	logic               degen_q;
	logic [1:0]         row_q;

	logic [63:0]        ormag;
	logic               sc_hi, sc_lo, vec_zero;
	logic [59:0]        sq;
	logic [63:0]        trial, r_nx;
	logic               take_r, take_d;
	logic [QW-1:0]      q_fin;
	logic [31:0]        nz, n_val;
	logic [1:0]         ip, iq;
	logic signed [31:0] op_a, op_b;
	logic signed [63:0] prod, acc_nx, rnd, tneg;
	logic signed [31:0] sat;
	logic               mac_last, out_free, out_load;

	// scaling, squares, root and divide helpers
	always_comb begin
		ormag    = mag_q[0] | mag_q[1] | mag_q[2];
		sc_hi    = |ormag[63:30];
		sc_lo    = !ormag[29];
		vec_zero = (vec_q[0] == '0) && (vec_q[1] == '0) && (vec_q[2] == '0);
		sq       = mag_q[k_q][29:0] * mag_q[k_q][29:0];
		trial    = rr_q + rbit_q;
		take_r   = (rn_q >= trial);
		r_nx     = take_r ? ((rr_q >> 1) + rbit_q) : (rr_q >> 1);
		take_d   = (rem_q >= den_q);
		q_fin    = {quo_q[QW-2:0], take_d};
		nz       = {{(32 - QW){1'b0}}, q_fin};
		n_val    = neg_q[k_q] ? 32'(-nz) : nz;
	end

	// shared multiply-accumulate
	always_comb begin
		ip = nx3(k_q);
		iq = nx3(ip);
		case (op_q)
			lavm_pkg::MAC_CROSS: begin
				op_a = step_q[0] ? up_q[iq] : up_q[ip];
				op_b = step_q[0] ? f_q[ip] : f_q[iq];
			end
			lavm_pkg::MAC_UP: begin
				op_a = step_q[0] ? f_q[iq] : f_q[ip];
				op_b = step_q[0] ? s_q[ip] : s_q[iq];
			end
			lavm_pkg::MAC_DOT: begin
				case (k_q)
					2'd0:    op_a = s_q[step_q];
					2'd1:    op_a = u_q[step_q];
					default: op_a = f_q[step_q];
				endcase
				op_b = eye_q[step_q];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		prod     = op_a * op_b;
		acc_nx   = (op_q != lavm_pkg::MAC_DOT && step_q[0]) ? acc_q - prod : acc_q + prod;
		rnd      = (acc_nx + HALF) >>> FRAC_BITS;
		tneg     = -rnd;
		mac_last = (op_q == lavm_pkg::MAC_DOT) ? (step_q == 2'd2) : (step_q == 2'd1);
		if (tneg > MAXV) begin
			sat = 32'h7FFF_FFFF;
		end else if (tneg < MINV) begin
			sat = 32'h8000_0000;
		end else begin
			sat = tneg[31:0];
		end
	end

	assign out_free = !out_valid || !out_stall;
	assign out_load = (state_q == lavm_pkg::ST_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lavm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			lavm_pkg::ST_IDLE: begin
				q_pop = q_valid;
				if (q_valid) begin
					state_d = q_item.dlt_zero ? lavm_pkg::ST_EMIT : lavm_pkg::ST_ABS;
				end
			end
			lavm_pkg::ST_ABS: begin
				state_d = vec_zero ? lavm_pkg::ST_EMIT : lavm_pkg::ST_SCALE;
			end
			lavm_pkg::ST_SCALE: begin
				if (!sc_hi && !sc_lo) begin
					state_d = lavm_pkg::ST_SQ;
				end
			end
			lavm_pkg::ST_SQ: begin
				if (k_q == 2'd2) begin
					state_d = lavm_pkg::ST_ROOT;
				end
			end
			lavm_pkg::ST_ROOT: begin
				if (rbit_q[0]) begin
					state_d = lavm_pkg::ST_DLOAD;
				end
			end
			lavm_pkg::ST_DLOAD: begin
				state_d = lavm_pkg::ST_DIV;
			end
			lavm_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = (k_q == 2'd2) ? lavm_pkg::ST_MAC : lavm_pkg::ST_DLOAD;
				end
			end
			lavm_pkg::ST_MAC: begin
				if (mac_last && k_q == 2'd2) begin
					priority case (op_q)
						lavm_pkg::MAC_CROSS: state_d = lavm_pkg::ST_ABS;
						lavm_pkg::MAC_DOT:   state_d = lavm_pkg::ST_EMIT;
						default:             state_d = lavm_pkg::ST_MAC;
					endcase
				end
			end
			lavm_pkg::ST_EMIT: begin
				if (out_free && row_q == lavm_pkg::ROW_TRANS) begin
					state_d = lavm_pkg::ST_IDLE;
				end
			end
			default: state_d = lavm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lavm_pkg::ST_IDLE: begin
				if (q_valid) begin
					for (int i = 0; i < 3; i++) begin
						vec_q[i] <= 64'($signed(q_item.dlt[i]));
						eye_q[i] <= q_item.eye[i];
						up_q[i]  <= q_item.up[i];
					end
					pass_q  <= 1'b0;
					degen_q <= q_item.dlt_zero;
					row_q   <= lavm_pkg::ROW_SIDE;
				end
			end
			lavm_pkg::ST_ABS: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= vec_q[i][63] ? 64'(-vec_q[i]) : 64'(vec_q[i]);
					neg_q[i] <= vec_q[i][63];
				end
				degen_q <= vec_zero;
				row_q   <= lavm_pkg::ROW_SIDE;
			end
			lavm_pkg::ST_SCALE: begin
				// one bit a cycle until the largest magnitude sits in [2^29, 2^30)
				for (int i = 0; i < 3; i++) begin
					if (sc_hi) begin
						mag_q[i] <= mag_q[i] >> 1;
					end else if (sc_lo) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end
				acc_q <= '0;
				k_q   <= 2'd0;
			end
			lavm_pkg::ST_SQ: begin
				acc_q <= acc_q + $signed({4'b0, sq});
				k_q   <= k_q + 2'd1;
				if (k_q == 2'd2) begin
					rn_q   <= 64'(acc_q) + {4'b0, sq};
					rr_q   <= '0;
					rbit_q <= 64'd1 << 62;
					k_q    <= 2'd0;
				end
			end
			lavm_pkg::ST_ROOT: begin
				if (take_r) begin
					rn_q <= rn_q - trial;
				end
				rr_q   <= r_nx;
				rbit_q <= rbit_q >> 2;
				if (rbit_q[0]) begin
					len_q <= r_nx[31:0];
				end
			end
			lavm_pkg::ST_DLOAD: begin
				// rounded quotient: add half the length before dividing
				rem_q <= (mag_q[k_q] << FRAC_BITS) + {33'd0, len_q[31:1]};
				den_q <= {32'd0, len_q} << (QW - 1);
				quo_q <= '0;
				cnt_q <= CW'(QW - 1);
			end
			lavm_pkg::ST_DIV: begin
				if (take_d) begin
					rem_q <= rem_q - den_q;
				end
				den_q <= den_q >> 1;
				quo_q <= q_fin;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					if (pass_q) begin
						s_q[k_q] <= n_val;
					end else begin
						f_q[k_q] <= n_val;
					end
					if (k_q == 2'd2) begin
						k_q    <= 2'd0;
						step_q <= 2'd0;
						acc_q  <= '0;
						op_q   <= pass_q ? lavm_pkg::MAC_UP : lavm_pkg::MAC_CROSS;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
			end
			lavm_pkg::ST_MAC: begin
				acc_q  <= acc_nx;
				step_q <= step_q + 2'd1;
				if (mac_last) begin
					acc_q  <= '0;
					step_q <= 2'd0;
					case (op_q)
						lavm_pkg::MAC_CROSS: vec_q[k_q] <= acc_nx;
						lavm_pkg::MAC_UP:    u_q[k_q]   <= rnd[31:0];
						default:             t_q[k_q]   <= sat;
					endcase
					if (k_q == 2'd2) begin
						k_q <= 2'd0;
						if (op_q == lavm_pkg::MAC_CROSS) begin
							pass_q <= 1'b1;
						end else if (op_q == lavm_pkg::MAC_UP) begin
							op_q <= lavm_pkg::MAC_DOT;
						end
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
			end
			lavm_pkg::ST_EMIT: begin
				if (out_free) begin
					row_q <= row_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			row_number <= row_q;
			last_row   <= (row_q == lavm_pkg::ROW_TRANS);
			degenerate <= degen_q;
			if (degen_q) begin
				elem_0 <= '0;
				elem_1 <= '0;
				elem_2 <= '0;
				elem_3 <= '0;
			end else begin
				unique case (row_q)
					lavm_pkg::ROW_SIDE: begin
						elem_0 <= s_q[0];
						elem_1 <= s_q[1];
						elem_2 <= s_q[2];
						elem_3 <= '0;
					end
					lavm_pkg::ROW_UP: begin
						elem_0 <= u_q[0];
						elem_1 <= u_q[1];
						elem_2 <= u_q[2];
						elem_3 <= '0;
					end
					lavm_pkg::ROW_FWD: begin
						elem_0 <= f_q[0];
						elem_1 <= f_q[1];
						elem_2 <= f_q[2];
						elem_3 <= '0;
					end
					default: begin
						elem_0 <= t_q[0];
						elem_1 <= t_q[1];
						elem_2 <= t_q[2];
						elem_3 <= ONE;
					end
				endcase
			end
		end
	end

endmodule

// ===== design/look_at_view_matrix.sv =====
// look-at view matrix top level: front queue and back sequencer
// the wait from input beat to first row is set by the back sequencer
// (one bit a cycle for scaling, 32 root steps and FRAC_BITS+2 divide steps per component);
// the sequencer skips to the zero rows when target equals eye or when the side axis vanishes
// throughput: one item per back pass, four row beats per item, one a cycle unless stalled
// arst_n clears queue pointers, sequencer state and the output valid; no clearing pass
module look_at_view_matrix #(
	parameter int FRAC_BITS   = lavm_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = lavm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] elem_0,
	output logic signed [31:0] elem_1,
	output logic signed [31:0] elem_2,
	output logic signed [31:0] elem_3,
	output logic [1:0]         row_number,
	output logic               last_row,
	output logic               degenerate
);

	// classified item handed from the front to the back
	lavm_pkg::item_t q_item;
	logic            q_valid;
	logic            q_pop;

	// front: takes a beat whenever the queue has room, forms target minus eye
	// and flags a zero forward vector early
	lavm_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.target_x (target_x),
		.target_y (target_y),
		.target_z (target_z),
		.eye_x    (eye_x),
		.eye_y    (eye_y),
		.eye_z    (eye_z),
		.up_x     (up_x),
		.up_y     (up_y),
		.up_z     (up_z),
		.q_item   (q_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop)
	);

	// back: normalises forward, crosses with up, normalises side, forms true up
	// and the eye dot products on one shared multiplier, then emits four rows
	// through a registered output stage
	lavm_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_item     (q_item),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.elem_0     (elem_0),
		.elem_1     (elem_1),
		.elem_2     (elem_2),
		.elem_3     (elem_3),
		.row_number (row_number),
		.last_row   (last_row),
		.degenerate (degenerate)
	);

endmodule

// ===== design/lavm_checker.sv =====
// port-level checks for the look-at view matrix, bound to the top level
`include "look_at_view_matrix_macros.svh"

module lavm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] elem_0,
	input logic signed [31:0] elem_1,
	input logic signed [31:0] elem_2,
	input logic signed [31:0] elem_3,
	input logic [1:0]         row_number,
	input logic               last_row,
	input logic               degenerate
);

	// a stalled row beat holds
	`LAVM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(elem_0) && $stable(elem_3) && $stable(row_number))

	`LAVM_ASSERT_IMPLY(a_last_row, out_valid, last_row == (row_number == lavm_pkg::ROW_TRANS))

	`LAVM_ASSERT_IMPLY(a_degen_zero, out_valid && degenerate, elem_0 == '0 && elem_1 == '0 && elem_2 == '0 && elem_3 == '0)

	`LAVM_ASSERT_IMPLY(a_axis_w, out_valid && !last_row, elem_3 == '0)

	// rows of one item follow in order
	`LAVM_ASSERT_NEXT(a_row_order, out_valid && !out_stall && !last_row, !out_valid || row_number == 2'($past(row_number) + 2'd1))

endmodule

bind look_at_view_matrix lavm_checker u_lavm_checker (.*);
